// ===== src/srot_pkg.sv =====
// Shared types and constants for the byte stack with rotate engine.
// Used by srot_cell, stack_with_rotate_engine and srot_checker.
`timescale 1ns / 1ps

package srot_pkg;

  // built depth default and field widths
  localparam int DEPTH_DEF   = 32;
  localparam int CAP_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int CNT_W       = 6;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // register word index taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  // request codes
  typedef enum logic [2:0] {
    REQ_PUSH  = 3'd0,
    REQ_POP   = 3'd1,
    REQ_PEEK  = 3'd2,
    REQ_DUP   = 3'd3,
    REQ_UROT  = 3'd4,
    REQ_DROT  = 3'd5,
    REQ_PRINT = 3'd6
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_DATA  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // per-cell load select
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_ABOVE = 2'd1,
    CELL_BELOW = 2'd2,
    CELL_BCAST = 2'd3
  } cell_op_e;

endpackage

// ===== src/srot_cell.sv =====
// One stack entry of the cell row: a byte register with a four-way load select.
// Depends on srot_pkg for cell_op_e.
`timescale 1ns / 1ps

module srot_cell (
  input  logic                 clk_i,
  input  srot_pkg::cell_op_e   op_i,
  input  logic [7:0]           above_i,
  input  logic [7:0]           below_i,
  input  logic [7:0]           bcast_i,
  output logic [7:0]           q_o
);
  import srot_pkg::*;

  logic [7:0] data_q;
  logic [7:0] data_d;

  // pick the next byte: keep, neighbor toward top, neighbor toward bottom, or broadcast
  always_comb begin
    case (op_i)
      CELL_ABOVE: data_d = above_i;
      CELL_BELOW: data_d = below_i;
      CELL_BCAST: data_d = bcast_i;
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

// ===== src/stack_with_rotate_engine.sv =====
// A single-result request gives its registered result in the cycle after it is accepted.
// One request per cycle while in_stall_o is low; every operation but print, a full rotate
// window too, is at most one shift of the cell row. Print of f entries gives f results
// (one row rotation per result) and holds off new requests until its last result.
// Reset clears fill level and output valid and sets capacity to 32; cell bytes are not cleared.
`timescale 1ns / 1ps

module stack_with_rotate_engine #(
  parameter int DEPTH = srot_pkg::DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [2:0]                       req_type_i,
  input  logic [7:0]                       data_in_i,
  input  logic [5:0]                       rotate_count_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [7:0]                       data_out_o,
  output logic                             last_item_o,
  // configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srot_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [srot_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [srot_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import srot_pkg::*;

  localparam int FW = $clog2(DEPTH + 1);

  // index 0 is the top of the stack
  logic [7:0]     cell_q  [DEPTH];
  cell_op_e       cell_op [DEPTH];
  logic [7:0]     bcast;

  logic [CAP_W-1:0] capacity_q;
  logic [FW-1:0]    fill_q, fill_d;
  logic             print_q, print_d;
  logic [FW-1:0]    left_q, left_d;

  logic             out_valid_q, out_valid_d;
  status_e          status_q, status_d;
  logic [7:0]       data_q, data_d;
  logic             last_q, last_d;
  logic             out_load;

  logic             in_take;
  logic             out_free;
  logic             is_full;
  logic             is_empty;
  logic             rot_ok;
  logic [7:0]       rot_pick;
  int               rot_n;
  int               fill_n;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY)) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DATA_W'(capacity_q) : '0;

  // handshake
  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = print_q | ~out_free;
  assign in_take    = in_valid_i & ~in_stall_o;

  // stack conditions
  assign fill_n   = int'(fill_q);
  assign rot_n    = int'(rotate_count_i);
  assign is_empty = (fill_q == '0);
  assign is_full  = (fill_n >= int'(capacity_q)) || (fill_n >= DEPTH);
  assign rot_ok   = (rotate_count_i != '0) && (rot_n <= fill_n);

  // byte at depth n for down-rotate
  always_comb begin
    rot_pick = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == rot_n - 1) begin
        rot_pick = cell_q[i];
      end
    end
  end

  // request decode, cell row control and result load
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_op[i] = CELL_HOLD;
    end
    bcast    = data_in_i;
    fill_d   = fill_q;
    print_d  = print_q;
    left_d   = left_q;
    out_load = 1'b0;
    status_d = ST_DONE;
    data_d   = '0;
    last_d   = 1'b1;

    if (in_take) begin
      out_load = 1'b1;
      unique case (req_e'(req_type_i))
        REQ_PUSH: begin
          if (is_full) begin
            status_d = ST_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              cell_op[i] = (i == 0) ? CELL_BCAST : CELL_ABOVE;
            end
            fill_d = fill_q + FW'(1);
          end
        end
        REQ_POP: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              cell_op[i] = CELL_BELOW;
            end
            fill_d   = fill_q - FW'(1);
            status_d = ST_DATA;
            data_d   = cell_q[0];
          end
        end
        REQ_PEEK: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else begin
            status_d = ST_DATA;
            data_d   = cell_q[0];
          end
        end
        REQ_DUP: begin
          if (is_empty) begin
            status_d = ST_EMPTY;
          end else if (is_full) begin
            status_d = ST_FULL;
          end else begin
            for (int i = 1; i < DEPTH; i++) begin
              cell_op[i] = CELL_ABOVE;
            end
            fill_d = fill_q + FW'(1);
          end
        end
        REQ_UROT: begin
          if (rot_ok) begin
            bcast = cell_q[0];
            for (int i = 0; i < DEPTH; i++) begin
              if (i < rot_n - 1) begin
                cell_op[i] = CELL_BELOW;
              end else if (i == rot_n - 1) begin
                cell_op[i] = CELL_BCAST;
              end
            end
          end
        end
        REQ_DROT: begin
          if (rot_ok) begin
            bcast = rot_pick;
            for (int i = 0; i < DEPTH; i++) begin
              if (i == 0) begin
                cell_op[i] = CELL_BCAST;
              end else if (i < rot_n) begin
                cell_op[i] = CELL_ABOVE;
              end
            end
          end
        end
        REQ_PRINT: begin
          if (!is_empty) begin
            out_load = 1'b0;
            print_d  = 1'b1;
            left_d   = fill_q;
          end
        end
        default: begin
          status_d = ST_DONE;
        end
      endcase
    end else if (print_q && out_free) begin
      // emit the top, then rotate the whole filled window up by one
      out_load = 1'b1;
      status_d = ST_DATA;
      data_d   = cell_q[0];
      last_d   = (left_q == FW'(1));
      bcast    = cell_q[0];
      for (int i = 0; i < DEPTH; i++) begin
        if (i < fill_n - 1) begin
          cell_op[i] = CELL_BELOW;
        end else if (i == fill_n - 1) begin
          cell_op[i] = CELL_BCAST;
        end
      end
      left_d = left_q - FW'(1);
      if (left_q == FW'(1)) begin
        print_d = 1'b0;
      end
    end
  end

  assign out_valid_d = out_load | (out_valid_q & out_stall_i);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      print_q     <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      print_q     <= print_d;
      left_q      <= left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      data_q   <= data_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign data_out_o  = data_q;
  assign last_item_o = last_q;

  // row of cells, each wired to its neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [7:0] above;
    logic [7:0] below;

    if (g == 0) begin : g_top
      assign above = bcast;
    end else begin : g_mid_a
      assign above = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_bot
      assign below = bcast;
    end else begin : g_mid_b
      assign below = cell_q[g+1];
    end

    srot_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .above_i (above),
      .below_i (below),
      .bcast_i (bcast),
      .q_o     (cell_q[g])
    );
  end

endmodule

// ===== src/srot_checker.sv =====
// Port-level checks for stack_with_rotate_engine, attached by bind.
// Depends on srot_pkg for the status codes.
`timescale 1ns / 1ps

module srot_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [7:0] data_out_o,
  input logic       last_item_o
);
  import srot_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(status_o) && $stable(data_out_o)
      && $stable(last_item_o))
    else $error("stalled result changed");

  // no new request while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("request taken while result blocked");

  // only data results may be non-final
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DATA) |-> last_item_o)
    else $error("non-data result without last mark");

  // data byte is zero unless data is valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_DATA) |-> (data_out_o == 8'h00))
    else $error("data byte set on non-data result");

endmodule

bind stack_with_rotate_engine srot_checker u_srot_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .status_o    (status_o),
  .data_out_o  (data_out_o),
  .last_item_o (last_item_o)
);
